// ===== hw/rtl/bbl_pkg.sv =====
// shared types and constants of the 9x9 box blur
package bbl_pkg;

  localparam int RADIUS_DEF    = 4;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int OUT_COL_W    = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [OUT_COL_W-1:0] col_out_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } in_item_t;

  typedef struct packed {
    pix_t     blurred;
    row_t     out_row;
    col_out_t out_col;
    logic     last_of_frame;
  } out_item_t;

  // position information carried alongside each item
  typedef struct packed {
    logic     emit;
    logic     last;
    row_t     row;
    col_out_t col;
  } tag_t;

endpackage

// ===== hw/rtl/bbl_ram.sv =====
// generic single write port ram with registered read
module bbl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bbl_pos.sv =====
// size registers and raster position tracking
module bbl_pos #(
  parameter int RADIUS    = bbl_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF,
  localparam int COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [bbl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              accept,
  input  logic                              frame_start,
  output logic [COL_W-1:0]                  col,
  output bbl_pkg::tag_t                     tag
);

  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int HIST  = 2 * RADIUS;
  localparam int CMP_W = bbl_pkg::HEIGHT_REG_W + 1;

  logic [bbl_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [bbl_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [COL_W-1:0]                 col_cnt_r, col_cnt_nxt, col_cur, col_last;
  bbl_pkg::row_t                    row_cnt_r, row_cnt_nxt, row_cur, row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbl_pkg::WIDTH_RESET;
      height_r <= bbl_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bbl_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[bbl_pkg::WIDTH_REG_W-1:0];
        bbl_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated last column and last row
  always_comb begin
    if (CMP_W'(width_r) < CMP_W'(SPAN)) begin
      col_last = COL_W'(SPAN - 1);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_r - 1'b1);
    end
    if (CMP_W'(height_r) < CMP_W'(SPAN)) begin
      row_last = bbl_pkg::row_t'(SPAN - 1);
    end else if (CMP_W'(height_r) > CMP_W'(bbl_pkg::MAX_HEIGHT)) begin
      row_last = bbl_pkg::row_t'(bbl_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last = bbl_pkg::row_t'(height_r - 1'b1);
    end
  end

  always_comb begin
    col_cur = frame_start ? '0 : col_cnt_r;
    row_cur = frame_start ? '0 : row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (col_cur >= col_last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_cur >= row_last) ? '0 : row_cur + 1'b1;
      end else begin
        col_cnt_nxt = col_cur + 1'b1;
        row_cnt_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_comb begin
    col      = col_cur;
    tag.emit = (row_cur >= bbl_pkg::row_t'(HIST)) && (col_cur >= COL_W'(HIST));
    tag.last = (row_cur == row_last) && (col_cur == col_last);
    tag.row  = row_cur - bbl_pkg::row_t'(RADIUS);
    tag.col  = bbl_pkg::col_out_t'(col_cur - COL_W'(RADIUS));
  end

  a_row_steps_at_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (row_cnt_nxt != row_cur) |-> col_cnt_nxt == '0)
    else $error("row advanced without column wrap");

endmodule

// ===== hw/rtl/bbl_col.sv =====
// column history ram, forwarding and column sum
module bbl_col #(
  parameter int RADIUS    = bbl_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int CS_W     = $clog2((2 * RADIUS + 1) * ((1 << bbl_pkg::PIX_W) - 1) + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             accept,
  input  logic [COL_W-1:0] rd_col,
  input  bbl_pkg::pix_t    pixel,
  input  bbl_pkg::tag_t    tag_in,
  output logic             b_valid,
  output bbl_pkg::tag_t    b_tag,
  output logic [CS_W-1:0]  b_colsum
);

  localparam int HIST   = 2 * RADIUS;
  localparam int HIST_W = HIST * bbl_pkg::PIX_W;

  logic                 a_valid_r, a_fwd_r, a_fwd_nxt;
  logic [COL_W-1:0]     a_col_r;
  bbl_pkg::pix_t        a_pix_r;
  bbl_pkg::tag_t        a_tag_r;
  logic [HIST_W-1:0]    a_fwd_data_r;
  logic [HIST_W-1:0]    ram_rd, hist_cur, hist_upd;
  logic                 wr_en;
  logic [CS_W-1:0]      colsum;
  logic                 b_valid_r;
  bbl_pkg::tag_t        b_tag_r;
  logic [CS_W-1:0]      b_colsum_r;

  assign wr_en     = adv && a_valid_r;
  assign a_fwd_nxt = accept && a_valid_r && (a_col_r == rd_col);

  bbl_ram #(
    .W     (HIST_W),
    .DEPTH (MAX_WIDTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (a_col_r),
    .wr_data (hist_upd),
    .rd_en   (accept),
    .rd_addr (rd_col),
    .rd_data (ram_rd)
  );

  // oldest pixel in the low byte
  assign hist_cur = a_fwd_r ? a_fwd_data_r : ram_rd;
  assign hist_upd = {a_pix_r, hist_cur[HIST_W-1:bbl_pkg::PIX_W]};

  always_comb begin
    colsum = CS_W'(a_pix_r);
    for (int i = 0; i < HIST; i++) begin
      colsum = colsum + CS_W'(hist_cur[i*bbl_pkg::PIX_W +: bbl_pkg::PIX_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_fwd_r   <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= accept;
      a_fwd_r   <= a_fwd_nxt;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r      <= rd_col;
      a_pix_r      <= pixel;
      a_tag_r      <= tag_in;
      a_fwd_data_r <= hist_upd;
    end
    if (adv && a_valid_r) begin
      b_tag_r    <= a_tag_r;
      b_colsum_r <= colsum;
    end
  end

  assign b_valid  = b_valid_r;
  assign b_tag    = b_tag_r;
  assign b_colsum = b_colsum_r;

  a_fwd_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    a_fwd_r |-> a_valid_r)
    else $error("forward flag without item");

  a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && accept && (rd_col == a_col_r) |=> a_fwd_r)
    else $error("read of column being written not forwarded");

endmodule

// ===== hw/rtl/bbl_win.sv =====
// window of column sums, total, divide by area and result register
module bbl_win #(
  parameter int RADIUS = bbl_pkg::RADIUS_DEF,
  localparam int CS_W  = $clog2((2 * RADIUS + 1) * ((1 << bbl_pkg::PIX_W) - 1) + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                b_valid,
  input  bbl_pkg::tag_t       b_tag,
  input  logic [CS_W-1:0]     b_colsum,
  output logic                out_valid,
  output bbl_pkg::out_item_t  out_item
);

  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int AREA   = SPAN * SPAN;
  localparam int SUM_W  = $clog2(AREA * ((1 << bbl_pkg::PIX_W) - 1) + 1);
  localparam int SHIFT  = 2 * $clog2(AREA) + bbl_pkg::PIX_W;
  localparam int PROD_W = SUM_W + SHIFT + 1;
  localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'(((64'd1 << SHIFT) + AREA - 1) / AREA);

  logic [CS_W-1:0]    win_r [SPAN];
  logic               c_valid_r, d_valid_r, out_valid_r;
  bbl_pkg::tag_t      c_tag_r, d_tag_r;
  logic [SUM_W-1:0]   total, d_total_r;
  logic [PROD_W-1:0]  prod;
  bbl_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SPAN; k++) begin
        win_r[k] <= '0;
      end
    end else if (adv && b_valid) begin
      for (int k = 0; k < SPAN - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[SPAN-1] <= b_colsum;
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < SPAN; k++) begin
      total = total + SUM_W'(win_r[k]);
    end
  end

  // floor division by the area through a rounded-up reciprocal
  assign prod = PROD_W'(d_total_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r   <= b_valid;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r && d_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      c_tag_r <= b_tag;
    end
    if (adv && c_valid_r) begin
      d_tag_r   <= c_tag_r;
      d_total_r <= total;
    end
    if (adv && d_valid_r && d_tag_r.emit) begin
      out_item_r.blurred       <= prod[SHIFT +: bbl_pkg::PIX_W];
      out_item_r.out_row       <= d_tag_r.row;
      out_item_r.out_col       <= d_tag_r.col;
      out_item_r.last_of_frame <= d_tag_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(d_valid_r && d_tag_r.emit))
    else $error("result without interior item");

endmodule

// ===== hw/rtl/box_blur_9x9.sv =====
// streaming 9x9 box blur top level
// throughput: one item per cycle when not stalled, set by the two-port column history ram
// (one read and one write each cycle, with a bypass for back-to-back column reuse)
// stalls only when the result register is full and out_ready is low
// reset clears position and window registers and sets the size registers to 512 by 512; the history ram is not cleared
module box_blur_9x9 #(
  parameter int RADIUS    = bbl_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bbl_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bbl_pkg::out_item_t             out_item
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CS_W  = $clog2((2 * RADIUS + 1) * ((1 << bbl_pkg::PIX_W) - 1) + 1);

  logic             adv, accept;
  logic [COL_W-1:0] col;
  bbl_pkg::tag_t    tag, b_tag;
  logic             b_valid;
  logic [CS_W-1:0]  b_colsum;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && adv;
  assign cfg_ready = 1'b1;

  bbl_pos #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .frame_start (in_item.frame_start),
    .col         (col),
    .tag         (tag)
  );

  bbl_col #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (accept),
    .rd_col   (col),
    .pixel    (in_item.pixel),
    .tag_in   (tag),
    .b_valid  (b_valid),
    .b_tag    (b_tag),
    .b_colsum (b_colsum)
  );

  bbl_win #(
    .RADIUS (RADIUS)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .b_valid   (b_valid),
    .b_tag     (b_tag),
    .b_colsum  (b_colsum),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/box_blur_9x9_tb.sv =====
// self-checking testbench for the streaming 9x9 box blur
module box_blur_9x9_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPAN      = 2 * bbl_pkg::RADIUS_DEF + 1;
  localparam int HIST      = 2 * bbl_pkg::RADIUS_DEF;
  localparam int AREA      = SPAN * SPAN;
  localparam int DRAIN_CYC = 12;
  localparam int LONG_HOLD = 400;
  localparam int RAND_ITEMS = 620;

  typedef enum int {FILL_UNIFORM, FILL_BRIGHT, FILL_DARK, FILL_BINARY, FILL_WHITE, FILL_BLACK}
    fill_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bbl_pkg::CFG_IDX_W-1:0]       cfg_index = bbl_pkg::REG_IMAGE_WIDTH;
  logic [bbl_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  bbl_pkg::in_item_t                   in_item = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  bbl_pkg::out_item_t                  out_item;

  bbl_pkg::in_item_t                   pixel_q [$];
  bbl_pkg::out_item_t                  blur_q [$];
  int unsigned                         in_gap = 0;
  int unsigned                         out_gap = 0;
  int unsigned                         hold_left = 0;
  int unsigned                         hold_req = 0;
  int unsigned                         hold_seen = 0;
  bit                                  send_idle_en = 1'b1;
  bit                                  recv_idle_en = 1'b1;
  int unsigned                         n_fail = 0;

  // predictor state
  bbl_pkg::pix_t                       col_hist [bbl_pkg::MAX_WIDTH_DEF][HIST];
  bbl_pkg::pix_t                       win [SPAN][SPAN];
  int unsigned                         col_pos = 0;
  int unsigned                         row_pos = 0;
  logic [bbl_pkg::WIDTH_REG_W-1:0]     width_reg = bbl_pkg::WIDTH_RESET;
  logic [bbl_pkg::HEIGHT_REG_W-1:0]    height_reg = bbl_pkg::HEIGHT_RESET;

  box_blur_9x9 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_width();
    return (width_reg < SPAN) ? SPAN :
           (width_reg > bbl_pkg::MAX_WIDTH_DEF) ? bbl_pkg::MAX_WIDTH_DEF : width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < SPAN) ? SPAN :
           (height_reg > bbl_pkg::MAX_HEIGHT) ? bbl_pkg::MAX_HEIGHT : height_reg;
  endfunction

  function automatic void blur_step(bbl_pkg::in_item_t it);
    int unsigned w, h, c, r, sum, slot;
    bbl_pkg::out_item_t res;
    w = eff_width();
    h = eff_height();
    if (it.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    slot = c % bbl_pkg::MAX_WIDTH_DEF;
    for (int k = 0; k < SPAN - 1; k++)
      for (int i = 0; i < SPAN; i++)
        win[k][i] = win[k + 1][i];
    for (int i = 0; i < HIST; i++)
      win[SPAN - 1][i] = col_hist[slot][i];
    win[SPAN - 1][HIST] = it.pixel;
    for (int i = 0; i < HIST - 1; i++)
      col_hist[slot][i] = col_hist[slot][i + 1];
    col_hist[slot][HIST - 1] = it.pixel;
    if (r >= HIST && c >= HIST) begin
      sum = 0;
      for (int k = 0; k < SPAN; k++)
        for (int i = 0; i < SPAN; i++)
          sum += win[k][i];
      res.blurred       = bbl_pkg::pix_t'(sum / AREA);
      res.out_row       = bbl_pkg::row_t'(r - bbl_pkg::RADIUS_DEF);
      res.out_col       = bbl_pkg::col_out_t'(c - bbl_pkg::RADIUS_DEF);
      res.last_of_frame = (r == h - 1) && (c == w - 1);
      blur_q.push_back(res);
    end
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void check_blur(bbl_pkg::out_item_t got);
    bbl_pkg::out_item_t want;
    if (blur_q.size() == 0) begin
      n_fail++;
      $display("%0t: unexpected result %p", $time, got);
      return;
    end
    want = blur_q.pop_front();
    if (got.blurred !== want.blurred) begin
      n_fail++;
      $display("%0t: blurred expected %0d got %0d", $time, want.blurred, got.blurred);
    end
    if (got.out_row !== want.out_row) begin
      n_fail++;
      $display("%0t: out_row expected %0d got %0d", $time, want.out_row, got.out_row);
    end
    if (got.out_col !== want.out_col) begin
      n_fail++;
      $display("%0t: out_col expected %0d got %0d", $time, want.out_col, got.out_col);
    end
    if (got.last_of_frame !== want.last_of_frame) begin
      n_fail++;
      $display("%0t: last_of_frame expected %0b got %0b", $time, want.last_of_frame,
               got.last_of_frame);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        blur_step(in_item);
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pixel_q.size() != 0) begin
          in_item  <= pixel_q.pop_front();
          in_valid <= 1'b1;
          in_gap   <= send_idle_en ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    int unsigned g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready)
        check_blur(out_item);
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_valid && out_ready) begin
        g = recv_idle_en ? $urandom_range(0, 5) : 0;
        out_gap   <= g;
        out_ready <= (g == 0);
      end else if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= (out_gap == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_size(bbl_pkg::cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bbl_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bbl_pkg::REG_IMAGE_WIDTH)
      width_reg = bbl_pkg::WIDTH_REG_W'(val);
    else
      height_reg = bbl_pkg::HEIGHT_REG_W'(val);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || blur_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic bbl_pkg::pix_t pick_pixel(fill_t fill);
    case (fill)
      FILL_BRIGHT: return bbl_pkg::pix_t'($urandom_range(240, 255));
      FILL_DARK:   return bbl_pkg::pix_t'($urandom_range(0, 15));
      FILL_BINARY: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      FILL_WHITE:  return 8'hff;
      FILL_BLACK:  return 8'h00;
      default:     return bbl_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // stray frame_start marks inside a frame when noisy
  function automatic void push_pixels(int unsigned n, fill_t fill, bit start, bit noisy);
    bbl_pkg::in_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.pixel       = pick_pixel(fill);
      it.frame_start = (i == 0) ? start : (noisy && $urandom_range(0, 149) == 0);
      pixel_q.push_back(it);
    end
  endfunction

  initial begin
    int unsigned rand_items, w_eff, h_eff, n, half, pick;
    bit start;
    fill_t fill;
    for (int c = 0; c < bbl_pkg::MAX_WIDTH_DEF; c++)
      for (int i = 0; i < HIST; i++)
        col_hist[c][i] = '0;
    for (int k = 0; k < SPAN; k++)
      for (int i = 0; i < SPAN; i++)
        win[k][i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes, part of the first row
    push_pixels(20, FILL_UNIFORM, 1'b1, 1'b0);
    wait_drained();

    // smallest frame, clamped from zero, position carried over from the reset width
    write_size(bbl_pkg::REG_IMAGE_WIDTH, 0);
    write_size(bbl_pkg::REG_IMAGE_HEIGHT, 0);
    @(negedge clk);
    push_pixels(81, FILL_WHITE, 1'b0, 1'b0);
    push_pixels(81, FILL_BLACK, 1'b0, 1'b0);
    push_pixels(20, FILL_UNIFORM, 1'b0, 1'b0);
    push_pixels(81, FILL_BINARY, 1'b1, 1'b0);
    wait_drained();

    // tallest frame, output held off so the block backs up
    write_size(bbl_pkg::REG_IMAGE_WIDTH, 9);
    write_size(bbl_pkg::REG_IMAGE_HEIGHT, bbl_pkg::MAX_HEIGHT);
    @(negedge clk);
    hold_req++;
    push_pixels(20 * 9, FILL_UNIFORM, 1'b1, 1'b0);
    wait_drained();

    // shrink the size while the position lies past the new edge
    write_size(bbl_pkg::REG_IMAGE_WIDTH, 16);
    write_size(bbl_pkg::REG_IMAGE_HEIGHT, 12);
    @(negedge clk);
    push_pixels(10 * 16 + 13, FILL_BRIGHT, 1'b1, 1'b0);
    wait_drained();
    write_size(bbl_pkg::REG_IMAGE_WIDTH, 10);
    write_size(bbl_pkg::REG_IMAGE_HEIGHT, 9);
    @(negedge clk);
    push_pixels(91, FILL_UNIFORM, 1'b0, 1'b0);
    wait_drained();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 7);
        write_size(bbl_pkg::REG_IMAGE_WIDTH, (pick == 0) ? $urandom_range(0, 8) :
                                             (pick == 1) ? $urandom_range(25, 40) :
                                                           $urandom_range(9, 20));
      end
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 7);
        write_size(bbl_pkg::REG_IMAGE_HEIGHT, (pick == 0) ? $urandom_range(0, 8) :
                                              (pick == 1) ? $urandom_range(4096, 8191) :
                                                            $urandom_range(9, 16));
      end
      @(negedge clk);
      w_eff = eff_width();
      h_eff = eff_height();
      repeat ($urandom_range(1, 3)) begin
        n = (h_eff > 32) ? w_eff * $urandom_range(9, 13) : w_eff * h_eff;
        if ($urandom_range(0, 4) == 0)
          n = $urandom_range(1, n);
        if (n > RAND_ITEMS - rand_items)
          n = RAND_ITEMS - rand_items;
        fill = fill_t'($urandom_range(0, 3));
        start = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) == 0) begin
          half = n / 2;
          push_pixels(half, fill, start, 1'b1);
          wait_drained();
          push_pixels(n - half, fill, (half == 0) && start, 1'b1);
        end else begin
          push_pixels(n, fill, start, 1'b1);
        end
        rand_items += n;
      end
      wait_drained();
    end

    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
